// File: rtl/epp_pkg.sv
// Package for the Euler pose point transform block.
// Types, fixed-point constants, the arctangent table and saturation helper.
// No dependencies.
`default_nettype none
package epp_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PT_MUL,
    S_PT_ACC,
    S_PT_OUT,
    S_IN_MAX,
    S_IN_CHK,
    S_IN_SHR,
    S_IN_SHL,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_SCL_MUL,
    S_SCL_ADD,
    S_RED_INIT,
    S_RED,
    S_FOLD1,
    S_FOLD2,
    S_ZRND,
    S_CORDIC,
    S_SC_STORE,
    S_MX_MUL,
    S_MX_ACC,
    S_DONE
  } state_t;

  // one queued item; v holds the point (0..2) or the six increments
  typedef struct packed {
    logic             inc;
    logic [5:0][31:0] v;
  } item_t;

  localparam logic [3:0] REG_INIT_X     = 4'd0;
  localparam logic [3:0] REG_INIT_Y     = 4'd1;
  localparam logic [3:0] REG_INIT_Z     = 4'd2;
  localparam logic [3:0] REG_INIT_ROLL  = 4'd3;
  localparam logic [3:0] REG_INIT_PITCH = 4'd4;
  localparam logic [3:0] REG_INIT_YAW   = 4'd5;
  localparam logic [3:0] REG_TRANS_STEP = 4'd6;
  localparam logic [3:0] REG_ROT_STEP   = 4'd7;

  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic [59:0]        TWO_PI    = 60'h06487ED5110B461;
  localparam logic signed [60:0] PI_Q52    = 61'sh03243F6A8885A31;
  localparam logic signed [60:0] HPI_Q52   = 61'sh01921FB54442D18;
  localparam logic [31:0]        STEP_ONE  = 32'd16777216;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd843314856;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043836;
      5'd3:  a = 34'sd133525158;
      5'd4:  a = 34'sd67021686;
      5'd5:  a = 34'sd33543515;
      5'd6:  a = 34'sd16775850;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194282;
      5'd9:  a = 34'sd2097149;
      default: a = 34'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/epp_front.sv
// Front end of the Euler pose point transform: a two-entry item queue.
// Sorts the payload by kind so the back end sees one vector. Uses epp_pkg.
`default_nettype none
module epp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic          kind,
  input  wire logic [31:0]   point_x,
  input  wire logic [31:0]   point_y,
  input  wire logic [31:0]   point_z,
  input  wire logic [31:0]   inc_x,
  input  wire logic [31:0]   inc_y,
  input  wire logic [31:0]   inc_z,
  input  wire logic [31:0]   inc_roll,
  input  wire logic [31:0]   inc_pitch,
  input  wire logic [31:0]   inc_yaw,
  output logic               q_valid,
  output epp_pkg::item_t     q_item,
  input  wire logic          q_pop
);

  epp_pkg::item_t slot [2];
  epp_pkg::item_t wr_item;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_item.inc = kind;
    if (kind) begin
      wr_item.v = {inc_yaw, inc_pitch, inc_roll, inc_z, inc_y, inc_x};
    end else begin
      wr_item.v = {96'd0, point_z, point_y, point_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/epp_back.sv
// Back end of the Euler pose point transform: pose, rotation matrix and a
// sequencer over one shared multiplier, CORDIC, square root and divider.
// Uses epp_pkg.
`default_nettype none
module epp_back #(
  parameter int CORDIC_STEPS    = 24,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire epp_pkg::item_t    q_item,
  output logic                   q_pop,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   res_valid,
  input  wire logic              res_pop,
  output logic [5:0][31:0]       res
);

  localparam int TSH = 54 - COORD_FRAC_BITS;
  localparam logic [4:0] CLAST = 5'(CORDIC_STEPS - 1);

  epp_pkg::state_t state, state_next;

  logic signed [31:0] t [3];
  logic signed [31:0] ang [3];
  logic signed [31:0] rot [9];
  logic [31:0]        tstep, rstep;

  logic signed [31:0] p [3];
  logic [31:0]        mag [6];
  logic [5:0]         neg;
  logic [31:0]        mmax;
  logic               from_item;

  logic [2:0] e;
  logic [1:0] row, col, asel;
  logic [3:0] idx, s;
  logic [2:0] k;
  logic [4:0] cnt;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;
  logic signed [65:0] acc;

  logic [63:0] sum, sqx, sqr, sqb;
  logic [32:0] rem;
  logic [31:0] nlow, quo;

  logic [59:0]        redm;
  logic               rsgn, sneg;
  logic signed [60:0] r;
  logic signed [33:0] cx, cy, cz;
  logic signed [33:0] sinv [3];
  logic signed [33:0] cosv [3];
  logic signed [33:0] srsp, crsp;
  logic signed [39:0] macc;

  // combinational helpers
  logic signed [71:0] ptv;
  logic [63:0]        sq_t1;
  logic               sq_ge;
  logic [32:0]        div_r2;
  logic               div_ge;
  logic [61:0]        num;
  logic [63:0]        pp;
  logic [34:0]        qmag;
  logic signed [35:0] qs;
  logic signed [31:0] pose_e;
  logic signed [31:0] pose_new;
  logic signed [60:0] rv;
  logic signed [60:0] zz;
  logic signed [39:0] m30;
  logic [31:0]        absang;

  // ---------------- operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      epp_pkg::S_PT_MUL: begin
        mul_a = 35'(rot[idx]);
        mul_b = 35'(p[col]);
      end
      epp_pkg::S_SQ_MUL: begin
        mul_a = {3'b0, mag[e]};
        mul_b = {3'b0, mag[e]};
      end
      epp_pkg::S_SCL_MUL: begin
        mul_a = {3'b0, quo};
        mul_b = {3'b0, (e < 3'd3) ? tstep : rstep};
      end
      epp_pkg::S_MX_MUL: begin
        case (s)
          4'd0:    begin mul_a = 35'(sinv[0]); mul_b = 35'(sinv[1]); end
          4'd1:    begin mul_a = 35'(cosv[0]); mul_b = 35'(sinv[1]); end
          4'd2:    begin mul_a = 35'(cosv[1]); mul_b = 35'(cosv[2]); end
          4'd3:    begin mul_a = 35'(cosv[1]); mul_b = 35'(sinv[2]); end
          4'd4:    begin mul_a = 35'(srsp);    mul_b = 35'(cosv[2]); end
          4'd5:    begin mul_a = 35'(cosv[0]); mul_b = 35'(sinv[2]); end
          4'd6:    begin mul_a = 35'(cosv[0]); mul_b = 35'(cosv[2]); end
          4'd7:    begin mul_a = 35'(srsp);    mul_b = 35'(sinv[2]); end
          4'd8:    begin mul_a = 35'(sinv[0]); mul_b = 35'(cosv[1]); end
          4'd9:    begin mul_a = 35'(sinv[0]); mul_b = 35'(sinv[2]); end
          4'd10:   begin mul_a = 35'(crsp);    mul_b = 35'(cosv[2]); end
          4'd11:   begin mul_a = 35'(crsp);    mul_b = 35'(sinv[2]); end
          4'd12:   begin mul_a = 35'(sinv[0]); mul_b = 35'(cosv[2]); end
          default: begin mul_a = 35'(cosv[0]); mul_b = 35'(cosv[1]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- datapath helpers
  always_comb begin
    ptv    = 72'((acc + 66'sd134217728) >>> 28) + 72'(t[row]);
    sq_t1  = sqr + sqb;
    sq_ge  = (sqx >= sq_t1);
    div_r2 = {rem[31:0], nlow[31]};
    div_ge = (div_r2 >= {1'b0, sqr[31:0]});
    num    = {mag[e][31:0], 30'd0} + 62'(sqr[31:1]);
    pp     = prod[63:0];
    if (e < 3'd3) begin
      qmag = 35'((pp + (64'd1 << (TSH - 1))) >> TSH);
      pose_e = t[e[1:0]];
    end else begin
      qmag = 35'((pp + (64'd1 << 29)) >> 30);
      pose_e = ang[2'(e - 3'd3)];
    end
    qs       = neg[e] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    pose_new = epp_pkg::sat32(72'(qs) + 72'(pose_e));
    rv       = rsgn ? -$signed({1'b0, redm}) : $signed({1'b0, redm});
    zz       = (r + 61'sd2097152) >>> 22;
    m30      = 40'((prod + 70'sd536870912) >>> 30);
    absang   = ang[asel][31] ? 32'(-ang[asel]) : ang[asel];
  end

  // ---------------- outputs of the sequencer
  always_comb begin
    cfg_ready = (state == epp_pkg::S_IDLE);
    q_pop     = (state == epp_pkg::S_IDLE) && !cfg_valid && q_valid && !res_valid;
  end

  // ---------------- next state
  always_comb begin
    state_next = state;
    case (state)
      epp_pkg::S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index <= epp_pkg::REG_INIT_YAW) state_next = epp_pkg::S_RED_INIT;
        end else if (q_pop) begin
          state_next = q_item.inc ? epp_pkg::S_IN_MAX : epp_pkg::S_PT_MUL;
        end
      end
      epp_pkg::S_PT_MUL: state_next = epp_pkg::S_PT_ACC;
      epp_pkg::S_PT_ACC: state_next = (col == 2'd2) ? epp_pkg::S_PT_OUT : epp_pkg::S_PT_MUL;
      epp_pkg::S_PT_OUT: state_next = (row == 2'd2) ? epp_pkg::S_DONE : epp_pkg::S_PT_MUL;
      epp_pkg::S_IN_MAX: state_next = (e == 3'd5) ? epp_pkg::S_IN_CHK : epp_pkg::S_IN_MAX;
      epp_pkg::S_IN_CHK: begin
        if (mmax == 32'd0) state_next = epp_pkg::S_RED_INIT;
        else if (mmax >= 32'h4000_0000) state_next = epp_pkg::S_IN_SHR;
        else if (mmax < 32'h2000_0000) state_next = epp_pkg::S_IN_SHL;
        else state_next = epp_pkg::S_SQ_MUL;
      end
      epp_pkg::S_IN_SHR: state_next = epp_pkg::S_IN_CHK;
      epp_pkg::S_IN_SHL: state_next = epp_pkg::S_IN_CHK;
      epp_pkg::S_SQ_MUL: state_next = epp_pkg::S_SQ_ACC;
      epp_pkg::S_SQ_ACC: state_next = (e == 3'd5) ? epp_pkg::S_SQRT : epp_pkg::S_SQ_MUL;
      epp_pkg::S_SQRT:   state_next = (cnt == 5'd31) ? epp_pkg::S_DIV_INIT : epp_pkg::S_SQRT;
      epp_pkg::S_DIV_INIT: state_next = epp_pkg::S_DIV;
      epp_pkg::S_DIV:    state_next = (cnt == 5'd31) ? epp_pkg::S_SCL_MUL : epp_pkg::S_DIV;
      epp_pkg::S_SCL_MUL: state_next = epp_pkg::S_SCL_ADD;
      epp_pkg::S_SCL_ADD:
        state_next = (e == 3'd5) ? epp_pkg::S_RED_INIT : epp_pkg::S_DIV_INIT;
      epp_pkg::S_RED_INIT: state_next = epp_pkg::S_RED;
      epp_pkg::S_RED:    state_next = (k == 3'd0) ? epp_pkg::S_FOLD1 : epp_pkg::S_RED;
      epp_pkg::S_FOLD1:  state_next = epp_pkg::S_FOLD2;
      epp_pkg::S_FOLD2:  state_next = epp_pkg::S_ZRND;
      epp_pkg::S_ZRND:
        state_next = (zz == 61'sd0) ? epp_pkg::S_SC_STORE : epp_pkg::S_CORDIC;
      epp_pkg::S_CORDIC:
        state_next = (cnt == CLAST) ? epp_pkg::S_SC_STORE : epp_pkg::S_CORDIC;
      epp_pkg::S_SC_STORE:
        state_next = (asel == 2'd2) ? epp_pkg::S_MX_MUL : epp_pkg::S_RED_INIT;
      epp_pkg::S_MX_MUL: state_next = epp_pkg::S_MX_ACC;
      epp_pkg::S_MX_ACC: begin
        if (s != 4'd13) state_next = epp_pkg::S_MX_MUL;
        else state_next = from_item ? epp_pkg::S_DONE : epp_pkg::S_IDLE;
      end
      epp_pkg::S_DONE: state_next = epp_pkg::S_IDLE;
      default: state_next = epp_pkg::S_IDLE;
    endcase
  end

  // ---------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= epp_pkg::S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        t[i]   <= '0;
        ang[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        rot[i] <= (i % 4 == 0) ? epp_pkg::ONE_Q30 : 32'sd0;
      end
      tstep <= epp_pkg::STEP_ONE;
      rstep <= epp_pkg::STEP_ONE;
    end else begin
      state <= state_next;
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        epp_pkg::S_IDLE: begin
          if (cfg_valid) begin
            from_item <= 1'b0;
            asel      <= 2'd0;
            case (cfg_index)
              epp_pkg::REG_INIT_X:     t[0]   <= cfg_data;
              epp_pkg::REG_INIT_Y:     t[1]   <= cfg_data;
              epp_pkg::REG_INIT_Z:     t[2]   <= cfg_data;
              epp_pkg::REG_INIT_ROLL:  ang[0] <= cfg_data;
              epp_pkg::REG_INIT_PITCH: ang[1] <= cfg_data;
              epp_pkg::REG_INIT_YAW:   ang[2] <= cfg_data;
              epp_pkg::REG_TRANS_STEP: tstep  <= cfg_data;
              epp_pkg::REG_ROT_STEP:   rstep  <= cfg_data;
              default: ;
            endcase
          end else if (q_pop) begin
            from_item <= 1'b1;
            for (int i = 0; i < 3; i++) p[i] <= q_item.v[i];
            for (int i = 0; i < 6; i++) begin
              neg[i] <= q_item.v[i][31];
              mag[i] <= q_item.v[i][31] ? 32'(-q_item.v[i]) : q_item.v[i];
            end
            mmax <= '0;
            e    <= '0;
            acc  <= '0;
            row  <= '0;
            col  <= '0;
            idx  <= '0;
            sum  <= '0;
            asel <= '0;
          end
        end
        epp_pkg::S_PT_MUL: prod <= mul_a * mul_b;
        epp_pkg::S_PT_ACC: begin
          acc <= acc + 66'(prod >>> 2);
          idx <= idx + 4'd1;
          col <= (col == 2'd2) ? 2'd0 : col + 2'd1;
        end
        epp_pkg::S_PT_OUT: begin
          acc      <= '0;
          row      <= row + 2'd1;
        end
        epp_pkg::S_IN_MAX: begin
          if (mag[e] > mmax) mmax <= mag[e];
          e <= (e == 3'd5) ? 3'd0 : e + 3'd1;
        end
        epp_pkg::S_IN_SHR: begin
          mmax <= mmax >> 1;
          for (int i = 0; i < 6; i++) mag[i] <= mag[i] >> 1;
        end
        epp_pkg::S_IN_SHL: begin
          mmax <= mmax << 1;
          for (int i = 0; i < 6; i++) mag[i] <= mag[i] << 1;
        end
        epp_pkg::S_SQ_MUL: prod <= mul_a * mul_b;
        epp_pkg::S_SQ_ACC: begin
          sum <= sum + pp;
          if (e == 3'd5) begin
            sqx <= sum + pp;
            sqr <= '0;
            sqb <= 64'd1 << 62;
            cnt <= '0;
            e   <= '0;
          end else begin
            e <= e + 3'd1;
          end
        end
        epp_pkg::S_SQRT: begin
          // one result bit per pass, bit walks down by two
          if (sq_ge) begin
            sqx <= sqx - sq_t1;
            sqr <= (sqr >> 1) + sqb;
          end else begin
            sqr <= sqr >> 1;
          end
          sqb <= sqb >> 2;
          cnt <= cnt + 5'd1;
        end
        epp_pkg::S_DIV_INIT: begin
          rem  <= 33'(num[61:32]);
          nlow <= num[31:0];
          quo  <= '0;
          cnt  <= '0;
        end
        epp_pkg::S_DIV: begin
          rem  <= div_ge ? div_r2 - {1'b0, sqr[31:0]} : div_r2;
          quo  <= {quo[30:0], div_ge};
          nlow <= nlow << 1;
          cnt  <= cnt + 5'd1;
        end
        epp_pkg::S_SCL_MUL: prod <= mul_a * mul_b;
        epp_pkg::S_SCL_ADD: begin
          if (e < 3'd3) t[e[1:0]] <= pose_new;
          else ang[2'(e - 3'd3)] <= pose_new;
          e    <= e + 3'd1;
          asel <= '0;
        end
        epp_pkg::S_RED_INIT: begin
          rsgn <= ang[asel][31];
          redm <= {absang, 28'd0};
          k    <= 3'd4;
        end
        epp_pkg::S_RED: begin
          if (redm >= (epp_pkg::TWO_PI << k)) redm <= redm - (epp_pkg::TWO_PI << k);
          k <= k - 3'd1;
        end
        epp_pkg::S_FOLD1: begin
          if (rv > epp_pkg::PI_Q52) r <= rv - $signed({1'b0, epp_pkg::TWO_PI});
          else if (rv < -epp_pkg::PI_Q52) r <= rv + $signed({1'b0, epp_pkg::TWO_PI});
          else r <= rv;
        end
        epp_pkg::S_FOLD2: begin
          // fold into the right half-plane; sine and cosine flip sign
          if (r > epp_pkg::HPI_Q52) begin
            r    <= r - epp_pkg::PI_Q52;
            sneg <= 1'b1;
          end else if (r < -epp_pkg::HPI_Q52) begin
            r    <= r + epp_pkg::PI_Q52;
            sneg <= 1'b1;
          end else begin
            sneg <= 1'b0;
          end
        end
        epp_pkg::S_ZRND: begin
          cy  <= '0;
          cz  <= 34'(zz);
          cnt <= '0;
          cx  <= (zz == 61'sd0) ? 34'(epp_pkg::ONE_Q30) : epp_pkg::GAIN_Q30;
        end
        epp_pkg::S_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - (cy >>> cnt);
            cy <= cy + (cx >>> cnt);
            cz <= cz - epp_pkg::atan_q30(cnt);
          end else begin
            cx <= cx + (cy >>> cnt);
            cy <= cy - (cx >>> cnt);
            cz <= cz + epp_pkg::atan_q30(cnt);
          end
          cnt <= cnt + 5'd1;
        end
        epp_pkg::S_SC_STORE: begin
          sinv[asel] <= sneg ? -cy : cy;
          cosv[asel] <= sneg ? -cx : cx;
          asel <= asel + 2'd1;
          s    <= '0;
          // sine of pitch goes straight into the matrix
          if (asel == 2'd1) begin
            rot[2] <= epp_pkg::sat32(72'(sneg ? -cy : cy));
          end
        end
        epp_pkg::S_MX_MUL: prod <= mul_a * mul_b;
        epp_pkg::S_MX_ACC: begin
          s <= s + 4'd1;
          case (s)
            4'd0:  srsp   <= 34'(m30);
            4'd1:  crsp   <= 34'(m30);
            4'd2:  rot[0] <= epp_pkg::sat32(72'(m30));
            4'd3:  rot[1] <= epp_pkg::sat32(-72'(m30));
            4'd5:  rot[3] <= epp_pkg::sat32(72'(macc) + 72'(m30));
            4'd7:  rot[4] <= epp_pkg::sat32(72'(macc) - 72'(m30));
            4'd8:  rot[5] <= epp_pkg::sat32(-72'(m30));
            4'd10: rot[6] <= epp_pkg::sat32(72'(macc) - 72'(m30));
            4'd12: rot[7] <= epp_pkg::sat32(72'(macc) + 72'(m30));
            4'd13: rot[8] <= epp_pkg::sat32(72'(m30));
            default: macc <= m30;
          endcase
        end
        epp_pkg::S_DONE: begin
          res_valid <= 1'b1;
        end
        default: ;
      endcase
      // increment results carry the new pose
      if (state == epp_pkg::S_MX_ACC && s == 4'd13 && from_item) begin
        for (int i = 0; i < 3; i++) begin
          res[i]     <= t[i];
          res[3 + i] <= ang[i];
        end
      end
      if (state == epp_pkg::S_PT_OUT) begin
        res[row] <= epp_pkg::sat32(ptv);
        for (int i = 3; i < 6; i++) res[i] <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/euler_pose_point_transform.sv
// Euler pose point transform: items go through a small input queue, then a
// sequencing back end that holds the pose and rotation. Uses epp_pkg,
// epp_front and epp_back.
//
// The block keeps a pose (translation plus roll, pitch, yaw) and the matrix
// R = Rx*Ry*Rz built from it with an iterative CORDIC. A point item returns
// R*p + t; its nine products share one multiplier. An increment item is
// normalised (max search, shift loop, squares, a square root, six divisions
// with scaling), added to the pose, and the matrix is rebuilt. Writing any of
// the six pose registers also rebuilds the matrix, during which cfg_ready is
// low. The queue holds two items; one finished result waits on the output
// ports.
`default_nettype none
module euler_pose_point_transform #(
  parameter int CORDIC_STEPS    = 24,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [31:0] inc_x,
  input  wire logic signed [31:0] inc_y,
  input  wire logic signed [31:0] inc_z,
  input  wire logic signed [31:0] inc_roll,
  input  wire logic signed [31:0] inc_pitch,
  input  wire logic signed [31:0] inc_yaw,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_roll,
  output logic signed [31:0]      out_pitch,
  output logic signed [31:0]      out_yaw,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic             q_valid, q_pop, res_valid;
  epp_pkg::item_t   q_item;
  logic [5:0][31:0] res;

  epp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .inc_x     (inc_x),
    .inc_y     (inc_y),
    .inc_z     (inc_z),
    .inc_roll  (inc_roll),
    .inc_pitch (inc_pitch),
    .inc_yaw   (inc_yaw),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  epp_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty     = !res_valid;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_roll  = res[3];
  assign out_pitch = res[4];
  assign out_yaw   = res[5];

endmodule
`default_nettype wire

// File: sim/tb_euler_pose_point_transform.sv
// Testbench for euler_pose_point_transform: directed and random point and
// increment beats, checked against a fixed-point predictor of pose and matrix.
// Depends on rtl/epp_pkg.sv and rtl/euler_pose_point_transform.sv.
`default_nettype none

module tb_euler_pose_point_transform;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] f[6];
  } pose_result_t;

  // Predictor of the pose and rotation, plus the queue of expected results
  class pose_scoreboard;
    logic signed [31:0] trans[3];
    logic signed [31:0] ang[3];
    logic signed [31:0] rot[9];
    logic [31:0] tstep, rstep;
    pose_result_t pending[$];
    int mismatches;
    int checked;

    function new();
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < 3; i++) begin
        trans[i] = 0;
        ang[i] = 0;
      end
      for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? epp_pkg::ONE_Q30 : 0;
      tstep = epp_pkg::STEP_ONE;
      rstep = epp_pkg::STEP_ONE;
    endfunction

    static function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    static function longint arctan(int i);
      longint t[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return t[i];
      return 64'sd1 <<< (30 - i);
    endfunction

    static function void sine_cosine(logic signed [31:0] a, output longint sn,
                                     output longint cs);
      longint r, x, y, z, dx, dy;
      bit flip;
      r = longint'(a) * 64'sd268435456;
      flip = 0;
      x = 652032874;
      y = 0;
      r = r % 64'sh6487ED5110B461;
      if (r > 64'sh3243F6A8885A31) r -= 64'sh6487ED5110B461;
      if (r < -64'sh3243F6A8885A31) r += 64'sh6487ED5110B461;
      if (r > 64'sh1921FB54442D18) begin
        r -= 64'sh3243F6A8885A31;
        flip = 1;
      end else if (r < -64'sh1921FB54442D18) begin
        r += 64'sh3243F6A8885A31;
        flip = 1;
      end
      z = (r + (64'sd1 <<< 21)) >>> 22;
      if (z == 0) x = 64'sd1073741824;
      else begin
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= arctan(i);
          end else begin
            x += dx; y -= dy; z += arctan(i);
          end
        end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function void build_rotation();
      longint sr, cr, sp, cp, sy, cy, srsp, crsp;
      sine_cosine(ang[0], sr, cr);
      sine_cosine(ang[1], sp, cp);
      sine_cosine(ang[2], sy, cy);
      srsp = q30_mul(sr, sp);
      crsp = q30_mul(cr, sp);
      rot[0] = sat(q30_mul(cp, cy));
      rot[1] = sat(-q30_mul(cp, sy));
      rot[2] = sat(sp);
      rot[3] = sat(q30_mul(srsp, cy) + q30_mul(cr, sy));
      rot[4] = sat(q30_mul(cr, cy) - q30_mul(srsp, sy));
      rot[5] = sat(-q30_mul(sr, cp));
      rot[6] = sat(q30_mul(sr, sy) - q30_mul(crsp, cy));
      rot[7] = sat(q30_mul(crsp, sy) + q30_mul(sr, cy));
      rot[8] = sat(q30_mul(cr, cp));
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] d);
      case (idx)
        epp_pkg::REG_INIT_X, epp_pkg::REG_INIT_Y, epp_pkg::REG_INIT_Z: begin
          trans[idx] = d;
          build_rotation();
        end
        epp_pkg::REG_INIT_ROLL, epp_pkg::REG_INIT_PITCH, epp_pkg::REG_INIT_YAW: begin
          ang[idx - epp_pkg::REG_INIT_ROLL] = d;
          build_rotation();
        end
        epp_pkg::REG_TRANS_STEP: tstep = d;
        epp_pkg::REG_ROT_STEP: rstep = d;
        default: ;
      endcase
    endfunction

    static function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    // note an accepted input beat and queue its expected result
    function void note_input(bit is_inc, logic signed [31:0] v[6]);
      pose_result_t e;
      longint unsigned mag[6], m, sum, n, u, p;
      bit neg[6];
      longint q, acc;
      int sh;
      for (int i = 0; i < 6; i++) e.f[i] = 0;
      if (!is_inc) begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++)
            acc += (longint'(rot[i * 3 + j]) * longint'(v[j])) >>> 2;
          e.f[i] = sat(((acc + (64'sd1 <<< 27)) >>> 28) + trans[i]);
        end
      end else begin
        m = 0;
        for (int i = 0; i < 6; i++) begin
          neg[i] = v[i] < 0;
          mag[i] = neg[i] ? -longint'(v[i]) : longint'(v[i]);
          if (mag[i] > m) m = mag[i];
        end
        if (m != 0) begin
          while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 6; i++) mag[i] >>= 1;
          end
          while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 6; i++) mag[i] <<= 1;
          end
          sum = 0;
          for (int i = 0; i < 6; i++) sum += mag[i] * mag[i];
          n = root(sum);
          for (int i = 0; i < 6; i++) begin
            u = ((mag[i] << 30) + (n >> 1)) / n;
            sh = (i < 3) ? 38 : 30;
            p = u * ((i < 3) ? tstep : rstep);
            q = longint'((p + (64'd1 << (sh - 1))) >> sh);
            if (neg[i]) q = -q;
            if (i < 3) trans[i] = sat(longint'(trans[i]) + q);
            else ang[i - 3] = sat(longint'(ang[i - 3]) + q);
          end
        end
        build_rotation();
        for (int i = 0; i < 3; i++) begin
          e.f[i] = trans[i];
          e.f[3 + i] = ang[i];
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] got[6]);
      pose_result_t e;
      string names[6] = '{"x", "y", "z", "roll", "pitch", "yaw"};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int i = 0; i < 6; i++)
        if (got[i] !== e.f[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d out_%s expected %0d got %0d",
                     checked, names[i], e.f[i], got[i]);
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0, pop = 0, kind = 0;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic signed [31:0] inc_x = 0, inc_y = 0, inc_z = 0;
  logic signed [31:0] inc_roll = 0, inc_pitch = 0, inc_yaw = 0;
  logic cfg_valid = 0;
  logic [3:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic full, empty, cfg_ready;
  logic signed [31:0] out_x, out_y, out_z, out_roll, out_pitch, out_yaw;

  pose_scoreboard board = new();
  bit quiet = 0;   // no idling on either side
  int n_points = 0, n_incs = 0, n_cfg = 0;

  always #1 clk = ~clk;

  euler_pose_point_transform uut (.*);

  // result side: random pop stalls, check on every accepted beat
  initial begin
    int stall;
    logic signed [31:0] got[6];
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{out_x, out_y, out_z, out_roll, out_pitch, out_yaw};
        board.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        pop <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        pop <= 0;
      end else pop <= 1;
    end
  end

  // push stays high between back-to-back beats; it drops only while idling or settling
  task automatic send(bit is_inc, logic signed [31:0] v[6]);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    kind <= is_inc;
    point_x <= is_inc ? $urandom : v[0];
    point_y <= is_inc ? $urandom : v[1];
    point_z <= is_inc ? $urandom : v[2];
    {inc_x, inc_y, inc_z} <= is_inc ? {v[0], v[1], v[2]} : {$urandom, $urandom, $urandom};
    {inc_roll, inc_pitch, inc_yaw} <= is_inc ? {v[3], v[4], v[5]} : {$urandom, $urandom, $urandom};
    push <= 1;
    do @(posedge clk); while (full);
    board.note_input(is_inc, v);
    if (is_inc) n_incs++; else n_points++;
  endtask

  task automatic settle();
    int guard = 0;
    push <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
    n_cfg++;
    cfg_valid <= 0;
    // let any rebuild start before looking at ready again
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF;
    endcase
  endfunction

  task automatic random_item(bit force_inc);
    logic signed [31:0] v[6];
    int mode = $urandom_range(0, 3);
    bit is_inc = force_inc || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 6; i++) begin
      v[i] = rnd_coord(mode);
      if (is_inc && $urandom_range(0, 5) == 0) v[i] = 0;
    end
    send(is_inc, v);
  endtask

  initial begin
    logic signed [31:0] v[6];
    logic signed [31:0] ext[6] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, 32'sh00010000};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero increment, single-axis increments
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 6; i++) v[i] = ext[(k + i) % 6];
      send(0, v);
    end
    v = '{0, 0, 0, 0, 0, 0};
    send(1, v);
    for (int k = 0; k < 6; k++) begin
      v = '{0, 0, 0, 0, 0, 0};
      v[k] = (k % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
      send(1, v);
      v = '{32'sh00010000, -32'sh00020000, 32'sh00030000, 0, 0, 0};
      send(0, v);
    end
    v = '{-1, 1, -1, 1, -1, 1};
    send(1, v);
    settle();

    // several register settings, extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_cfg(epp_pkg::REG_INIT_X, 32'h7FFFFFFF);
          write_cfg(epp_pkg::REG_INIT_Y, 32'h80000000);
          write_cfg(epp_pkg::REG_INIT_Z, 0);
          write_cfg(epp_pkg::REG_INIT_ROLL, 32'h7FFFFFFF);
          write_cfg(epp_pkg::REG_INIT_PITCH, 32'h80000000);
          write_cfg(epp_pkg::REG_INIT_YAW, 32'h01921FB5);
          write_cfg(epp_pkg::REG_TRANS_STEP, 32'hFFFFFFFF);
          write_cfg(epp_pkg::REG_ROT_STEP, 0);
        end
        1: begin
          write_cfg(epp_pkg::REG_TRANS_STEP, 0);
          write_cfg(epp_pkg::REG_ROT_STEP, 32'hFFFFFFFF);
          write_cfg(4'd9, $urandom);
        end
        4: begin
          write_cfg(epp_pkg::REG_TRANS_STEP, epp_pkg::STEP_ONE);
          write_cfg(epp_pkg::REG_ROT_STEP, epp_pkg::STEP_ONE);
          for (int r = 0; r < 6; r++) write_cfg(r[3:0], 0);
        end
        default: begin
          for (int r = 0; r < 8; r++) write_cfg(r[3:0], $urandom);
          write_cfg(epp_pkg::REG_TRANS_STEP, $urandom_range(0, 32'h04000000));
        end
      endcase
      if (phase == 4) quiet = 1;
      for (int n = 0; n < 80; n++) random_item(n % 16 == 0);
      settle();
    end

    $display("Covered %0d point beats, %0d increment beats and %0d register writes.",
             n_points, n_incs, n_cfg);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else begin
      $display("%0d mismatches, %0d results outstanding", board.mismatches,
               board.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// File: euler_pose_point_transform.f
rtl/epp_pkg.sv
rtl/epp_front.sv
rtl/epp_back.sv
rtl/euler_pose_point_transform.sv
sim/tb_euler_pose_point_transform.sv
